[rtl/core/psb_pkg.sv]
// Shared types, field widths and codes for the page slot bitmap allocator.
// Depends on nothing; every other file of the block imports it.
package psb_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_MAX_SLOTS  = 512;

  // The bitmap is stored and scanned as words of this many bits.
  localparam int WORD_BITS = 64;
  localparam int WORD_LSB  = 6;
  localparam int BYTE_LSB  = 3;
  localparam int PC_W      = WORD_LSB + 1;

  // Field widths of the channels and of the configuration register.
  localparam int MODE_W    = 3;
  localparam int SLOT_W    = 9;
  localparam int BIDX_W    = 6;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int FREE_W    = 10;
  localparam int RB_W      = 13;
  localparam int DIVISOR_W = RB_W + 3;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRHDR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RDHDR = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Request held for the whole scan and handed to the word unit.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [BIDX_W-1:0] bidx;
    logic [BYTE_W-1:0] bval;
    logic              slot_ok;
  } word_req_t;

  // What the word unit reports about one bitmap word.
  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic                 we;
    logic [PC_W-1:0]      free_cnt;
    logic                 hit;
    logic [WORD_LSB-1:0]  hit_bit;
    logic                 slot_hit;
    logic                 slot_bit;
    logic                 byte_hit;
    logic [BYTE_W-1:0]    byte_val;
  } word_res_t;

endpackage

[rtl/core/psb_if.sv]
// Request and response channel interfaces of the page slot bitmap allocator.
// Depends on psb_pkg for the field widths.
interface psb_req_if import psb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot;
  logic [BIDX_W-1:0] byte_index;
  logic [BYTE_W-1:0] byte_value;

  modport source(output valid, mode, slot, byte_index, byte_value, input ready);
  modport sink(input valid, mode, slot, byte_index, byte_value, output ready);
endinterface

interface psb_rsp_if import psb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic                slot_used;
  logic [FREE_W-1:0]   free_count;
  logic [BYTE_W-1:0]   byte_out;

  modport source(output valid, status, slot_out, slot_used, free_count, byte_out,
                 input ready);
  modport sink(input valid, status, slot_out, slot_used, free_count, byte_out,
               output ready);
endinterface

[rtl/core/psb_slot_divider.sv]
// Restoring divider that turns the record size into the usable slot count.
// Depends on psb_pkg; one quotient bit per cycle.
module psb_slot_divider import psb_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [RB_W-1:0]                    rb,
  output logic                               done,
  output logic [$clog2(MAX_SLOTS+1)-1:0]     slots
);

  localparam int PAGE_BITS = PAGE_BYTES * 8;
  localparam int DW        = $clog2(PAGE_BITS + 1);
  localparam int BIW       = $clog2(DW);
  localparam int USW       = $clog2(MAX_SLOTS + 1);
  localparam int CMPW      = (DW > USW) ? DW : USW;
  localparam logic [DW-1:0] DIVIDEND = DW'(PAGE_BITS);

  logic                 busy;
  logic [BIW-1:0]       bi;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] rem;
  logic [DW-1:0]        quo;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 ge;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem, DIVIDEND[bi]};
    rem_sub = rem_sh - {1'b0, divisor};
    ge      = rem_sh >= {1'b0, divisor};
  end

  // Sequencing of the DW steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && bi == '0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bi == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= {rb, 3'b000} + DIVISOR_W'(1);
      rem     <= '0;
      bi      <= BIW'(DW - 1);
    end else if (busy) begin
      rem <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo <= {quo[DW-2:0], ge};
      bi  <= bi - BIW'(1);
    end
  end

  // The page never holds more slots than the bitmap has bits.
  assign slots = (CMPW'(quo) > CMPW'(MAX_SLOTS)) ? USW'(MAX_SLOTS) : USW'(quo);

endmodule

[rtl/core/psb_word_unit.sv]
// Shared word unit: find-first-free, free, query, header byte and popcount
// on one 64-bit bitmap word. Depends on psb_pkg.
module psb_word_unit import psb_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  word_req_t                                 req,
  input  logic [WORD_BITS-1:0]                      word,
  input  logic [((MAX_SLOTS+WORD_BITS-1)/WORD_BITS > 1 ?
                 $clog2((MAX_SLOTS+WORD_BITS-1)/WORD_BITS) : 1)-1:0] widx,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]            usable,
  input  logic                                      found,
  output word_res_t                                 res
);

  localparam int NW   = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX = (NW > 1) ? $clog2(NW) : 1;
  localparam int USW  = $clog2(MAX_SLOTS + 1);
  localparam int AW   = USW + WORD_LSB + 1;

  // Mask of the bits of the word at base whose slot number is below lim.
  function automatic logic [WORD_BITS-1:0] mask_below(input logic [AW-1:0] lim,
                                                      input logic [AW-1:0] base);
    logic [AW-1:0]        diff;
    logic [WORD_BITS-1:0] m;
    diff = lim - base;
    if (lim <= base) begin
      m = '0;
    end else if (diff >= AW'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << diff[WORD_LSB-1:0]) - WORD_BITS'(1);
    end
    return m;
  endfunction

  logic [AW-1:0]        base;
  logic [WORD_BITS-1:0] use_mask;
  logic [WORD_BITS-1:0] cap_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [WORD_LSB-1:0]  sb;
  logic [WORD_LSB-1:0]  first;
  logic                 slot_match;
  logic                 byte_match;
  logic [WORD_BITS-1:0] nd;

  always_comb begin
    base       = AW'(widx) << WORD_LSB;
    use_mask   = mask_below(AW'(usable), base);
    cap_mask   = mask_below(AW'(MAX_SLOTS), base);
    sb         = req.slot[WORD_LSB-1:0];
    slot_match = (AW'(req.slot) >> WORD_LSB) == AW'(widx);
    byte_match = (AW'(req.bidx) >> BYTE_LSB) == AW'(widx);

    // Lowest free usable bit of the word.
    free_bits = ~word & use_mask;
    low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
    first     = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        first = WORD_LSB'(b);
      end
    end

    // Apply the request to this word.
    nd  = word;
    res = '0;
    case (req.mode)
      MODE_ALLOC: begin
        if (!found && free_bits != '0) begin
          nd          = word | low_bit;
          res.hit     = 1'b1;
          res.hit_bit = first;
        end
      end
      MODE_FREE: begin
        if (slot_match && req.slot_ok) begin
          nd[sb]       = 1'b0;
          res.slot_hit = 1'b1;
          res.slot_bit = word[sb];
        end
      end
      MODE_QUERY: begin
        if (slot_match && req.slot_ok) begin
          res.slot_hit = 1'b1;
          res.slot_bit = word[sb];
        end
      end
      MODE_WRHDR: begin
        if (byte_match) begin
          nd[{req.bidx[BYTE_LSB-1:0], 3'b000} +: BYTE_W] = req.bval;
          nd = nd & cap_mask;
        end
      end
      MODE_RDHDR: begin
        if (byte_match) begin
          res.byte_hit = 1'b1;
          res.byte_val = word[{req.bidx[BYTE_LSB-1:0], 3'b000} +: BYTE_W];
        end
      end
      default: begin
      end
    endcase

    // Write back only a changed word; count free bits after the change.
    res.data     = nd;
    res.we       = nd != word;
    res.free_cnt = PC_W'($countones(~nd & use_mask));
  end

endmodule

[rtl/core/page_slot_bitmap_allocator.sv]
// Page slot bitmap allocator: sequencer, bitmap word memory and result register.
// Depends on psb_pkg, psb_if, psb_slot_divider and psb_word_unit.
// A request's result is registered in the output register after the scan state and the
// done state; the scan runs through the word unit one 64-bit word per cycle. A new
// request is taken only back in idle, once the result has been loaded.
// A record size write holds ready low from its own cycle until the divider's slot count is loaded.
// Reset empties the page at once through per-word valid flags; no clearing pass.
module page_slot_bitmap_allocator import psb_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [RB_W-1:0] cfg_data,
  psb_req_if.sink         req,
  psb_rsp_if.source       rsp
);

  localparam int NW    = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX  = (NW > 1) ? $clog2(NW) : 1;
  localparam int WCW   = $clog2(NW + 1);
  localparam int USW   = $clog2(MAX_SLOTS + 1);
  localparam int AW    = USW + WORD_LSB + 1;
  localparam int RESET_RAW   = (PAGE_BYTES * 8) / (8 * 8 + 1);
  localparam int RESET_SLOTS = (RESET_RAW > MAX_SLOTS) ? MAX_SLOTS : RESET_RAW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t               state;
  logic [USW-1:0]       usable_slots;
  logic                 div_done;
  logic [USW-1:0]       div_slots;

  word_req_t            rq;
  logic [WCW-1:0]       ra;
  logic                 p_v;
  logic [WIDX-1:0]      p_w;
  logic                 found;
  logic [WIDX+WORD_LSB-1:0] alloc_slot;
  logic                 slot_bit;
  logic [BYTE_W-1:0]    byte_q;
  logic [USW-1:0]       cnt;

  logic [WORD_BITS-1:0] mem [NW];
  logic [NW-1:0]        wvalid;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;
  logic [WORD_BITS-1:0] word;
  word_res_t            res;
  logic                 we;
  logic                 accept;
  logic                 proc;
  logic                 load;

  logic [STATUS_W-1:0]  status_next;
  logic [SLOT_W-1:0]    slot_out_next;
  logic                 slot_used_next;
  logic [BYTE_W-1:0]    byte_out_next;

  assign req.ready = (state == S_IDLE) && !cfg_we;
  assign accept    = req.valid && req.ready;
  assign proc      = (state == S_SCAN) && p_v;
  assign we        = proc && res.we;
  assign load      = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign word      = rvalid ? rdata : '0;

  // Slot count unit for record size writes.
  psb_slot_divider #(
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cfg_we),
    .rb   (cfg_data),
    .done (div_done),
    .slots(div_slots)
  );

  // Shared word unit applied to each word of the scan.
  psb_word_unit #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_word (
    .req   (rq),
    .word  (word),
    .widx  (p_w),
    .usable(usable_slots),
    .found (found),
    .res   (res)
  );

  // Sequencer and usable slot count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      usable_slots <= USW'(RESET_SLOTS);
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            state <= S_DIV;
          end else if (accept) begin
            state <= S_SCAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            usable_slots <= div_slots;
            state        <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (p_v && ra == WCW'(NW)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan address, pipeline flag and result accumulation.
  always_ff @(posedge clk) begin
    if (accept) begin
      rq.mode    <= req.mode;
      rq.slot    <= req.slot;
      rq.bidx    <= req.byte_index;
      rq.bval    <= req.byte_value;
      rq.slot_ok <= AW'(req.slot) < AW'(usable_slots);
      ra         <= '0;
      p_v        <= 1'b0;
      found      <= 1'b0;
      alloc_slot <= '0;
      slot_bit   <= 1'b0;
      byte_q     <= '0;
      cnt        <= '0;
    end else if (state == S_SCAN) begin
      p_v <= ra < WCW'(NW);
      p_w <= ra[WIDX-1:0];
      if (ra < WCW'(NW)) begin
        ra <= ra + WCW'(1);
      end
      if (p_v) begin
        cnt <= cnt + USW'(res.free_cnt);
        if (res.hit) begin
          found      <= 1'b1;
          alloc_slot <= {p_w, res.hit_bit};
        end
        if (res.slot_hit) begin
          slot_bit <= res.slot_bit;
        end
        if (res.byte_hit) begin
          byte_q <= res.byte_val;
        end
      end
    end
  end

  // Bitmap word memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[p_w] <= res.data;
    end
    if (state == S_SCAN && ra < WCW'(NW)) begin
      rdata <= mem[ra[WIDX-1:0]];
    end
  end

  // Word valid flags: a word never written reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) begin
        wvalid[p_w] <= 1'b1;
      end
      if (state == S_SCAN && ra < WCW'(NW)) begin
        rvalid <= wvalid[ra[WIDX-1:0]];
      end
    end
  end

  // Response fields of the finished request.
  always_comb begin
    status_next    = ST_OK;
    slot_out_next  = '0;
    slot_used_next = 1'b0;
    byte_out_next  = '0;
    case (rq.mode)
      MODE_ALLOC: begin
        status_next   = found ? ST_OK : ST_FULL;
        slot_out_next = found ? SLOT_W'(alloc_slot) : '0;
      end
      MODE_FREE: begin
        slot_out_next = rq.slot;
        if (!rq.slot_ok) begin
          status_next = ST_RANGE;
        end else if (!slot_bit) begin
          status_next = ST_EMPTY;
        end
      end
      MODE_QUERY: begin
        slot_out_next  = rq.slot;
        status_next    = rq.slot_ok ? ST_OK : ST_RANGE;
        slot_used_next = rq.slot_ok && slot_bit;
      end
      MODE_RDHDR: begin
        byte_out_next = byte_q;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished beat while the next request runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status     <= status_next;
      rsp.slot_out   <= slot_out_next;
      rsp.slot_used  <= slot_used_next;
      rsp.byte_out   <= byte_out_next;
      rsp.free_count <= FREE_W'(cnt);
    end
  end

  // An accepted request always starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SCAN)
    else $error("accepted request did not start a scan");

  // The bitmap is written only while a scan runs.
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_SCAN)
    else $error("bitmap written outside a scan");

  // The slot count never exceeds the bitmap size.
  a_usable_cap: assert property (@(posedge clk) disable iff (rst)
    USW'(MAX_SLOTS) >= usable_slots)
    else $error("usable slot count above bitmap size");

  // The free count of a finished request never exceeds the usable slots.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> cnt <= usable_slots)
    else $error("free count above usable slots");

  // Allocation claims at most one slot per request.
  a_single_alloc: assert property (@(posedge clk) disable iff (rst)
    proc && res.hit |-> !found)
    else $error("second slot allocated in one request");

endmodule
